// ===== hw/rtl/whp_pkg.sv =====
// Shared types, codes and the sample type decode for the WAV header parser.
package whp_pkg;

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_BODY_BYTES = 32'd16;

    // result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_RIFF  = 3'd1;
    localparam logic [2:0] ST_BAD_WAVE  = 3'd2;
    localparam logic [2:0] ST_BAD_FMT   = 3'd3;
    localparam logic [2:0] ST_FMT_SMALL = 3'd4;
    localparam logic [2:0] ST_NO_DATA   = 3'd5;

    // format codes
    localparam logic [15:0] FC_PCM     = 16'd1;
    localparam logic [15:0] FC_MSADPCM = 16'd2;
    localparam logic [15:0] FC_FLOAT   = 16'd3;
    localparam logic [15:0] FC_ALAW    = 16'd6;
    localparam logic [15:0] FC_MULAW   = 16'd7;
    localparam logic [15:0] FC_DVIADPCM = 16'd17;

    // decoded sample types
    localparam logic [3:0] SMP_INVALID  = 4'd0;
    localparam logic [3:0] SMP_UPCM     = 4'd1;
    localparam logic [3:0] SMP_SPCM     = 4'd2;
    localparam logic [3:0] SMP_MSADPCM  = 4'd3;
    localparam logic [3:0] SMP_FLOAT    = 4'd4;
    localparam logic [3:0] SMP_DOUBLE   = 4'd5;
    localparam logic [3:0] SMP_ALAW     = 4'd6;
    localparam logic [3:0] SMP_MULAW    = 4'd7;
    localparam logic [3:0] SMP_DVIADPCM = 4'd8;

    localparam logic [3:0] FBODY_DEPTH_IDX = 4'd15;

    typedef enum logic [3:0] {
        PH_RIFF,
        PH_RSIZE,
        PH_WAVE,
        PH_FMT,
        PH_FSIZE,
        PH_FBODY,
        PH_FEXTRA,
        PH_CTAG,
        PH_CSIZE,
        PH_CSKIP,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] sample_hz;
        logic [15:0] channels;
        logic [15:0] sample_bits;
        logic [3:0]  sample_type;
        logic [31:0] bytes_per_second;
        logic [31:0] payload_size;
        logic [31:0] duration_seconds;
    } t_out;

    // controller -> datapath, all qualified by an accepted word
    typedef struct packed {
        logic       take;
        logic       count_word;
        logic       load_fsize;
        logic       fbody_step;
        logic       skip_dec;
        logic       load_tag;
        logic       load_size;
        logic       restart;
        logic       emit_err;
        logic [2:0] err_code;
        logic       emit_ok;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic word_last;
        logic tag_riff;
        logic tag_wave;
        logic tag_fmt;
        logic fsize_small;
        logic fbody_last;
        logic fsize_exact;
        logic skip_one;
        logic size_zero;
        logic cskip_last;
        logic chunk_is_data;
        logic div_busy;
        logic out_blocked;
    } t_stat;

    function automatic logic [3:0] decode_type(input logic [15:0] code,
                                               input logic [15:0] depth);
        logic [3:0] t;
        t = SMP_INVALID;
        case (code)
            FC_PCM:      t = (depth == 16'd8) ? SMP_UPCM : SMP_SPCM;
            FC_MSADPCM:  t = SMP_MSADPCM;
            FC_FLOAT:    t = (depth == 16'd64) ? SMP_DOUBLE : SMP_FLOAT;
            FC_ALAW:     t = SMP_ALAW;
            FC_MULAW:    t = SMP_MULAW;
            FC_DVIADPCM: t = SMP_DVIADPCM;
            default:     t = SMP_INVALID;
        endcase
        return t;
    endfunction

endpackage

// ===== hw/rtl/whp_div.sv =====
// Restoring divider, one quotient bit per cycle, for the duration result.
module whp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_quotient
);
    import whp_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_quo;
    logic [31:0] r_rem;
    logic [31:0] r_div;
    logic [32:0] s_trial;
    logic [32:0] s_diff;
    logic        s_ge;

    // a zero divisor always compares as fitting, so the quotient comes out all ones
    assign s_trial = {r_rem, r_quo[31]};
    assign s_ge    = (s_trial >= {1'b0, r_div});
    assign s_diff  = s_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= s_ge ? s_diff[31:0] : s_trial[31:0];
            r_quo <= {r_quo[30:0], s_ge};
        end
    end

    assign o_busy     = r_busy | r_done;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== hw/rtl/whp_dpath.sv =====
// Datapath: byte shifter, counters, captured format fields and result register.
module whp_dpath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [7:0]     i_data_byte,
    input  whp_pkg::t_cmd  i_cmd,
    output whp_pkg::t_stat o_stat,
    output logic           o_out_valid,
    output whp_pkg::t_out  o_out_data,
    input  logic           i_out_stall
);
    import whp_pkg::*;

    logic [31:0] r_shift;
    logic [31:0] n_shift;
    logic [1:0]  r_byte_cnt;
    logic [31:0] r_skip;
    logic        r_pad;
    logic [31:0] r_fsize;
    logic [15:0] r_fmt_code;
    logic [15:0] r_chan;
    logic [31:0] r_rate;
    logic [31:0] r_brate;
    logic [15:0] r_depth;
    logic        r_is_data;
    logic        r_out_valid;
    t_out        r_out;
    t_out        s_err_out;
    logic [3:0]  s_idx;
    logic        s_out_taken;
    logic        s_div_busy;
    logic        s_div_done;
    logic [31:0] s_quotient;

    // newest byte enters at the top
    assign n_shift     = {i_data_byte, r_shift[31:8]};
    assign s_idx       = r_skip[3:0];
    assign s_out_taken = r_out_valid & ~i_out_stall;

    always_comb begin
        s_err_out        = '0;
        s_err_out.status = i_cmd.err_code;
    end

    whp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.emit_ok),
        .i_dividend (n_shift),
        .i_divisor  (r_brate),
        .o_busy     (s_div_busy),
        .o_done     (s_div_done),
        .o_quotient (s_quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_cnt  <= '0;
            r_pad       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.restart) begin
                r_byte_cnt <= '0;
                r_pad      <= 1'b0;
            end else begin
                if (i_cmd.count_word) begin
                    r_byte_cnt <= r_byte_cnt + 2'd1;
                end
                if (i_cmd.load_size) begin
                    r_pad <= n_shift[0];
                end else if (i_cmd.skip_dec && r_skip == 32'd0) begin
                    r_pad <= 1'b0;
                end
            end
            if (i_cmd.emit_err || s_div_done) begin
                r_out_valid <= 1'b1;
            end else if (s_out_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_shift <= n_shift;
        end
        if (i_cmd.load_fsize) begin
            r_fsize <= n_shift;
            r_skip  <= '0;
        end
        if (i_cmd.fbody_step) begin
            if (s_idx == FBODY_DEPTH_IDX) begin
                r_skip <= r_fsize - FMT_BODY_BYTES;
            end else begin
                r_skip <= {28'd0, s_idx + 4'd1};
            end
            case (s_idx)
                4'd1:    r_fmt_code <= n_shift[31:16];
                4'd3:    r_chan     <= n_shift[31:16];
                4'd7:    r_rate     <= n_shift;
                4'd11:   r_brate    <= n_shift;
                4'd15:   r_depth    <= n_shift[31:16];
                default: ;
            endcase
        end
        if (i_cmd.skip_dec && r_skip != 32'd0) begin
            r_skip <= r_skip - 32'd1;
        end
        if (i_cmd.load_size) begin
            r_skip <= n_shift;
        end
        if (i_cmd.load_tag) begin
            r_is_data <= (n_shift == TAG_DATA);
        end
        if (i_cmd.emit_err) begin
            r_out <= s_err_out;
        end else if (i_cmd.emit_ok) begin
            r_out.status           <= ST_OK;
            r_out.sample_hz        <= r_rate;
            r_out.channels         <= r_chan;
            r_out.sample_bits      <= r_depth;
            r_out.sample_type      <= decode_type(r_fmt_code, r_depth);
            r_out.bytes_per_second <= r_brate;
            r_out.payload_size     <= n_shift;
        end
        if (s_div_done) begin
            r_out.duration_seconds <= s_quotient;
        end
    end

    always_comb begin
        o_stat.word_last     = (r_byte_cnt == 2'd3);
        o_stat.tag_riff      = (n_shift == TAG_RIFF);
        o_stat.tag_wave      = (n_shift == TAG_WAVE);
        o_stat.tag_fmt       = (n_shift == TAG_FMT);
        o_stat.fsize_small   = (n_shift[31:4] == 28'd0);
        o_stat.fbody_last    = (s_idx == FBODY_DEPTH_IDX);
        o_stat.fsize_exact   = (r_fsize == FMT_BODY_BYTES);
        o_stat.skip_one      = (r_skip == 32'd1);
        o_stat.size_zero     = (n_shift == 32'd0);
        // finish after the last body byte, or after the pad byte of an odd chunk
        o_stat.cskip_last    = ((r_skip == 32'd1) && !r_pad) || (r_skip == 32'd0);
        o_stat.chunk_is_data = r_is_data;
        o_stat.div_busy      = s_div_busy;
        o_stat.out_blocked   = r_out_valid & i_out_stall;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hw/rtl/whp_ctrl.sv =====
// Controller: parse phase state machine and input handshake.
module whp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_eos,
    input  whp_pkg::t_stat i_stat,
    output logic           o_in_stall,
    output whp_pkg::t_cmd  o_cmd
);
    import whp_pkg::*;

    t_phase r_phase;
    t_phase n_phase;
    t_cmd   s_cmd;
    logic   s_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RIFF;
        end else if (s_accept) begin
            r_phase <= n_phase;
        end
    end

    always_comb begin
        n_phase        = r_phase;
        s_cmd          = '0;
        s_cmd.take     = 1'b1;
        s_cmd.err_code = ST_OK;
        unique case (r_phase)
            PH_RIFF: begin
                s_cmd.count_word = 1'b1;
                if (i_stat.word_last) begin
                    if (i_stat.tag_riff) begin
                        n_phase = PH_RSIZE;
                    end else begin
                        s_cmd.emit_err = 1'b1;
                        s_cmd.err_code = ST_BAD_RIFF;
                        n_phase        = PH_DONE;
                    end
                end
            end
            PH_RSIZE: begin
                s_cmd.count_word = 1'b1;
                if (i_stat.word_last) begin
                    n_phase = PH_WAVE;
                end
            end
            PH_WAVE: begin
                s_cmd.count_word = 1'b1;
                if (i_stat.word_last) begin
                    if (i_stat.tag_wave) begin
                        n_phase = PH_FMT;
                    end else begin
                        s_cmd.emit_err = 1'b1;
                        s_cmd.err_code = ST_BAD_WAVE;
                        n_phase        = PH_DONE;
                    end
                end
            end
            PH_FMT: begin
                s_cmd.count_word = 1'b1;
                if (i_stat.word_last) begin
                    if (i_stat.tag_fmt) begin
                        n_phase = PH_FSIZE;
                    end else begin
                        s_cmd.emit_err = 1'b1;
                        s_cmd.err_code = ST_BAD_FMT;
                        n_phase        = PH_DONE;
                    end
                end
            end
            PH_FSIZE: begin
                s_cmd.count_word = 1'b1;
                if (i_stat.word_last) begin
                    if (i_stat.fsize_small) begin
                        s_cmd.emit_err = 1'b1;
                        s_cmd.err_code = ST_FMT_SMALL;
                        n_phase        = PH_DONE;
                    end else begin
                        s_cmd.load_fsize = 1'b1;
                        n_phase          = PH_FBODY;
                    end
                end
            end
            PH_FBODY: begin
                s_cmd.fbody_step = 1'b1;
                if (i_stat.fbody_last) begin
                    n_phase = i_stat.fsize_exact ? PH_CTAG : PH_FEXTRA;
                end
            end
            PH_FEXTRA: begin
                s_cmd.skip_dec = 1'b1;
                if (i_stat.skip_one) begin
                    n_phase = PH_CTAG;
                end
            end
            PH_CTAG: begin
                s_cmd.count_word = 1'b1;
                if (i_stat.word_last) begin
                    s_cmd.load_tag = 1'b1;
                    n_phase        = PH_CSIZE;
                end
            end
            PH_CSIZE: begin
                s_cmd.count_word = 1'b1;
                if (i_stat.word_last) begin
                    if (i_stat.chunk_is_data) begin
                        s_cmd.emit_ok = 1'b1;
                        n_phase       = PH_DONE;
                    end else begin
                        s_cmd.load_size = 1'b1;
                        n_phase = i_stat.size_zero ? PH_CTAG : PH_CSKIP;
                    end
                end
            end
            PH_CSKIP: begin
                s_cmd.skip_dec = 1'b1;
                if (i_stat.cskip_last) begin
                    n_phase = PH_CTAG;
                end
            end
            PH_DONE: begin
            end
            default: begin
                n_phase = PH_RIFF;
            end
        endcase

        // end of stream: report where the file stopped unless a result went out
        if (i_eos) begin
            if (!s_cmd.emit_err && !s_cmd.emit_ok && n_phase != PH_DONE) begin
                s_cmd.emit_err = 1'b1;
                if (n_phase == PH_RIFF) begin
                    s_cmd.err_code = ST_BAD_RIFF;
                end else if (n_phase == PH_RSIZE || n_phase == PH_WAVE) begin
                    s_cmd.err_code = ST_BAD_WAVE;
                end else if (n_phase == PH_FMT) begin
                    s_cmd.err_code = ST_BAD_FMT;
                end else begin
                    s_cmd.err_code = ST_NO_DATA;
                end
            end
            s_cmd.restart = 1'b1;
            n_phase       = PH_RIFF;
        end
    end

    // hold the word while dividing, or when any result meets a full output
    assign o_in_stall = i_stat.div_busy |
                        (i_stat.out_blocked & (s_cmd.emit_err | s_cmd.emit_ok));
    assign s_accept   = i_in_valid & ~o_in_stall;
    assign o_cmd      = s_accept ? s_cmd : '0;

endmodule

// ===== hw/rtl/wav_header_parser_unit.sv =====
// WAV header parser top level: one file byte per word, one result per file.
// Takes one byte per cycle unless stalled; an error result shows the cycle after
// its deciding byte. A good result runs a 32-step restoring divider: input stalls
// from the data chunk size byte until the divider is done and the result is ready.
// A byte that decides a result also stalls while the previous result is still held.
// Synchronous active-low reset clears phase, counters and output valid; eos restarts.
module wav_header_parser_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  whp_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output whp_pkg::t_out o_out_data,
    input  logic          i_out_stall
);
    import whp_pkg::*;

    t_cmd  s_cmd;
    t_stat s_stat;

    whp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_eos      (i_in_data.end_of_stream),
        .i_stat     (s_stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (s_cmd)
    );

    whp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_data_byte (i_in_data.data_byte),
        .i_cmd       (s_cmd),
        .o_stat      (s_stat),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
